/* design/ec_point_add_and_multiply_top_macros.svh */
// Assertion macros shared by the point arithmetic modules.
`ifndef EC_POINT_ADD_AND_MULTIPLY_TOP_MACROS_SVH
`define EC_POINT_ADD_AND_MULTIPLY_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define EC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define EC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/ecpa_pkg.sv */
// Types, codes and microprogram for the elliptic curve point unit.
`default_nettype none
package ecpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_RED, OP_MOV,
    OP_ZERO, OP_ONE, OP_LDM, OP_CMP, OP_SHN
  } dp_op_t;

  typedef enum logic [4:0] {
    R_PX, R_PY, R_TX, R_TY, R_SX, R_SY, R_RX, R_RY, R_CA, R_NUM,
    R_DEN, R_R0, R_R1, R_T0, R_T1, R_Q, R_LAM, R_X3, R_TMP
  } reg_id_t;

  localparam int REG_DEPTH = 32;

  typedef enum logic [2:0] {IN_PX, IN_PY, IN_QX, IN_QY, IN_CA} in_sel_t;

  typedef enum logic [2:0] {K_DP, K_BR, K_JMP, K_CALL, K_RET, K_SET, K_END} uop_kind_t;

  typedef enum logic [3:0] {
    C_MSMALL, C_MUL, C_NBIT0, C_MORE, C_SINF, C_TINF, C_EQ, C_NEQ, C_AZ, C_NA1
  } cond_t;

  typedef enum logic [2:0] {
    F_ADD_INIT, F_DBL, F_ADDP, F_R_T, F_R_S, F_R_ZERO, F_R_ONE
  } flag_set_t;

  typedef enum logic {CFG_MODULUS = 1'b0, CFG_CURVE_A = 1'b1} cfg_idx_t;

  localparam int PC_BITS = 7;
  typedef logic [PC_BITS-1:0] pc_t;

  typedef struct packed {
    uop_kind_t kind;
    dp_op_t    op;
    reg_id_t   dst;
    reg_id_t   dst2;
    reg_id_t   srca;
    reg_id_t   srcb;
    in_sel_t   insel;
    cond_t     cond;
    flag_set_t fset;
    pc_t       target;
  } uop_t;

  typedef struct packed {
    logic    start;
    logic    capture;
    dp_op_t  op;
    reg_id_t dst;
    reg_id_t dst2;
    reg_id_t srca;
    reg_id_t srcb;
    in_sel_t insel;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic az;
    logic a1;
    logic nbit;
    logic req_mul;
    logic msmall;
  } dp_status_t;

  // microprogram labels
  localparam pc_t L_MUL  = 7'd12;
  localparam pc_t L_LOOP = 7'd15;
  localparam pc_t L_NEXT = 7'd28;
  localparam pc_t L_INF  = 7'd31;
  localparam pc_t P_ADD  = 7'd33;
  localparam pc_t P_TAN  = 7'd40;
  localparam pc_t P_DEN  = 7'd48;
  localparam pc_t P_IL   = 7'd54;
  localparam pc_t P_IE   = 7'd64;
  localparam pc_t P_RT   = 7'd76;
  localparam pc_t P_RS   = 7'd80;
  localparam pc_t P_INF  = 7'd84;

  function automatic uop_t u_base(uop_kind_t k);
    uop_t u;
    u = '0;
    u.kind = k;
    return u;
  endfunction

  function automatic uop_t u_dp(dp_op_t op, reg_id_t dst, reg_id_t a, reg_id_t b);
    uop_t u;
    u = u_base(K_DP);
    u.op = op;
    u.dst = dst;
    u.srca = a;
    u.srcb = b;
    return u;
  endfunction

  function automatic uop_t u_red(in_sel_t sel, reg_id_t dst);
    uop_t u;
    u = u_base(K_DP);
    u.op = OP_RED;
    u.dst = dst;
    u.insel = sel;
    return u;
  endfunction

  function automatic uop_t u_div(reg_id_t a, reg_id_t b, reg_id_t q, reg_id_t r);
    uop_t u;
    u = u_dp(OP_DIV, q, a, b);
    u.dst2 = r;
    return u;
  endfunction

  function automatic uop_t u_br(cond_t c, pc_t t);
    uop_t u;
    u = u_base(K_BR);
    u.cond = c;
    u.target = t;
    return u;
  endfunction

  function automatic uop_t u_jmp(pc_t t);
    uop_t u;
    u = u_base(K_JMP);
    u.target = t;
    return u;
  endfunction

  function automatic uop_t u_set(flag_set_t f);
    uop_t u;
    u = u_base(K_SET);
    u.fset = f;
    return u;
  endfunction

  function automatic uop_t ucode(pc_t pc);
    uop_t u;
    case (pc)
      // request entry
      7'd0:  u = u_br(C_MSMALL, L_INF);
      7'd1:  u = u_red(IN_PX, R_PX);
      7'd2:  u = u_red(IN_PY, R_PY);
      7'd3:  u = u_red(IN_CA, R_CA);
      7'd4:  u = u_br(C_MUL, L_MUL);
      7'd5:  u = u_red(IN_QX, R_TX);
      7'd6:  u = u_red(IN_QY, R_TY);
      7'd7:  u = u_dp(OP_MOV, R_SX, R_PX, R_PX);
      7'd8:  u = u_dp(OP_MOV, R_SY, R_PY, R_PY);
      7'd9:  u = u_set(F_ADD_INIT);
      7'd10: begin u = u_base(K_CALL); u.target = P_ADD; end
      7'd11: u = u_base(K_END);
      // scalar multiply, double-and-add from the top bit
      7'd12: u = u_set(F_R_ONE);
      7'd13: u = u_dp(OP_ZERO, R_RX, R_TMP, R_TMP);
      7'd14: u = u_dp(OP_ZERO, R_RY, R_TMP, R_TMP);
      7'd15: u = u_dp(OP_MOV, R_SX, R_RX, R_RX);
      7'd16: u = u_dp(OP_MOV, R_SY, R_RY, R_RY);
      7'd17: u = u_dp(OP_MOV, R_TX, R_RX, R_RX);
      7'd18: u = u_dp(OP_MOV, R_TY, R_RY, R_RY);
      7'd19: u = u_set(F_DBL);
      7'd20: begin u = u_base(K_CALL); u.target = P_ADD; end
      7'd21: u = u_br(C_NBIT0, L_NEXT);
      7'd22: u = u_dp(OP_MOV, R_SX, R_RX, R_RX);
      7'd23: u = u_dp(OP_MOV, R_SY, R_RY, R_RY);
      7'd24: u = u_dp(OP_MOV, R_TX, R_PX, R_PX);
      7'd25: u = u_dp(OP_MOV, R_TY, R_PY, R_PY);
      7'd26: u = u_set(F_ADDP);
      7'd27: begin u = u_base(K_CALL); u.target = P_ADD; end
      7'd28: u = u_dp(OP_SHN, R_TMP, R_TMP, R_TMP);
      7'd29: u = u_br(C_MORE, L_LOOP);
      7'd30: u = u_base(K_END);
      7'd31: u = u_set(F_R_ONE);
      7'd32: u = u_base(K_END);
      // point add subroutine: R = S + T
      7'd33: u = u_br(C_SINF, P_RT);
      7'd34: u = u_br(C_TINF, P_RS);
      7'd35: u = u_dp(OP_CMP, R_TMP, R_SX, R_TX);
      7'd36: u = u_br(C_EQ, P_TAN);
      7'd37: u = u_dp(OP_SUB, R_NUM, R_TY, R_SY);
      7'd38: u = u_dp(OP_SUB, R_DEN, R_TX, R_SX);
      7'd39: u = u_jmp(P_DEN);
      7'd40: u = u_dp(OP_CMP, R_TMP, R_SY, R_TY);
      7'd41: u = u_br(C_NEQ, P_INF);
      7'd42: u = u_br(C_AZ, P_INF);
      7'd43: u = u_dp(OP_MUL, R_TMP, R_SX, R_SX);
      7'd44: u = u_dp(OP_ADD, R_NUM, R_TMP, R_TMP);
      7'd45: u = u_dp(OP_ADD, R_NUM, R_NUM, R_TMP);
      7'd46: u = u_dp(OP_ADD, R_NUM, R_NUM, R_CA);
      7'd47: u = u_dp(OP_ADD, R_DEN, R_SY, R_SY);
      7'd48: u = u_dp(OP_CMP, R_TMP, R_DEN, R_DEN);
      7'd49: u = u_br(C_AZ, P_INF);
      // extended Euclid: r0 = p, r1 = den, t0 = 0, t1 = 1
      7'd50: u = u_dp(OP_LDM, R_R0, R_TMP, R_TMP);
      7'd51: u = u_dp(OP_MOV, R_R1, R_DEN, R_DEN);
      7'd52: u = u_dp(OP_ZERO, R_T0, R_TMP, R_TMP);
      7'd53: u = u_dp(OP_ONE, R_T1, R_TMP, R_TMP);
      7'd54: u = u_dp(OP_CMP, R_TMP, R_R1, R_R1);
      7'd55: u = u_br(C_AZ, P_IE);
      7'd56: u = u_div(R_R0, R_R1, R_Q, R_TMP);
      7'd57: u = u_dp(OP_MUL, R_LAM, R_Q, R_T1);
      7'd58: u = u_dp(OP_SUB, R_X3, R_T0, R_LAM);
      7'd59: u = u_dp(OP_MOV, R_R0, R_R1, R_R1);
      7'd60: u = u_dp(OP_MOV, R_R1, R_TMP, R_TMP);
      7'd61: u = u_dp(OP_MOV, R_T0, R_T1, R_T1);
      7'd62: u = u_dp(OP_MOV, R_T1, R_X3, R_X3);
      7'd63: u = u_jmp(P_IL);
      7'd64: u = u_dp(OP_CMP, R_TMP, R_R0, R_R0);
      7'd65: u = u_br(C_NA1, P_INF);
      7'd66: u = u_dp(OP_MUL, R_LAM, R_NUM, R_T0);
      7'd67: u = u_dp(OP_MUL, R_TMP, R_LAM, R_LAM);
      7'd68: u = u_dp(OP_SUB, R_TMP, R_TMP, R_SX);
      7'd69: u = u_dp(OP_SUB, R_X3, R_TMP, R_TX);
      7'd70: u = u_dp(OP_SUB, R_TMP, R_SX, R_X3);
      7'd71: u = u_dp(OP_MUL, R_TMP, R_LAM, R_TMP);
      7'd72: u = u_dp(OP_SUB, R_RY, R_TMP, R_SY);
      7'd73: u = u_dp(OP_MOV, R_RX, R_X3, R_X3);
      7'd74: u = u_set(F_R_ZERO);
      7'd75: u = u_base(K_RET);
      7'd76: u = u_dp(OP_MOV, R_RX, R_TX, R_TX);
      7'd77: u = u_dp(OP_MOV, R_RY, R_TY, R_TY);
      7'd78: u = u_set(F_R_T);
      7'd79: u = u_base(K_RET);
      7'd80: u = u_dp(OP_MOV, R_RX, R_SX, R_SX);
      7'd81: u = u_dp(OP_MOV, R_RY, R_SY, R_SY);
      7'd82: u = u_set(F_R_S);
      7'd83: u = u_base(K_RET);
      7'd84: u = u_set(F_R_ONE);
      7'd85: u = u_base(K_RET);
      default: u = u_base(K_END);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

/* design/ecpa_if.sv */
// Request and result channel interfaces of the point unit.
`default_nettype none
interface ecpa_in_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic         req_type;
  logic [W-1:0] px;
  logic [W-1:0] py;
  logic [W-1:0] qx;
  logic [W-1:0] qy;
  logic [W-1:0] scalar;
  modport source (output valid, req_type, px, py, qx, qy, scalar, input ready);
  modport sink (input valid, req_type, px, py, qx, qy, scalar, output ready);
endinterface

interface ecpa_out_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] rx;
  logic [W-1:0] ry;
  logic         at_infinity;
  modport source (output valid, rx, ry, at_infinity, input ready);
  modport sink (input valid, rx, ry, at_infinity, output ready);
endinterface
`default_nettype wire

/* design/ecpa_dp.sv */
// Datapath: register file, modular add/sub, serial multiplier and divider.
`default_nettype none
`include "ec_point_add_and_multiply_top_macros.svh"
module ecpa_dp import ecpa_pkg::*; #(
  parameter int W = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [W-1:0] cfg_data,
  input  logic       in_req_type,
  input  logic [W-1:0] in_px,
  input  logic [W-1:0] in_py,
  input  logic [W-1:0] in_qx,
  input  logic [W-1:0] in_qy,
  input  logic [W-1:0] in_scalar,
  input  dp_cmd_t    cmd,
  output dp_status_t st,
  output logic [W-1:0] rx,
  output logic [W-1:0] ry
);

  localparam int CW = $clog2(W);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_EXEC = 5'b00010,
    D_ITER = 5'b00100,
    D_FIN  = 5'b01000,
    D_WR2  = 5'b10000
  } dp_state_t;

  dp_state_t state_r, state_nxt;

  logic [W-1:0] mem [REG_DEPTH];
  logic [W-1:0] mod_r, ca_r;
  logic [W-1:0] hpx_r, hpy_r, hqx_r, hqy_r, n_r;
  logic         mul_r;
  dp_op_t       op_r;
  reg_id_t      dst_r, dst2_r;
  in_sel_t      insel_r;
  logic [W-1:0] rda_r, rdb_r;
  logic [W-1:0] acc_r, u_r, v_r, rem_r;
  logic [CW-1:0] cnt_r;
  logic         eq_r, az_r, a1_r;
  logic [W-1:0] rx_r, ry_r;

  logic         we;
  reg_id_t      waddr;
  logic [W-1:0] wdata;
  logic [W-1:0] simple_res, in_sel_val, qfix;
  logic [W:0]   trial, trial_diff;
  logic         simple_op, done;

  function automatic logic [W-1:0] add_m(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] m);
    return (a >= m - b) ? a - (m - b) : a + b;
  endfunction

  function automatic logic [W-1:0] sub_m(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  always_comb begin
    case (insel_r)
      IN_PX:   in_sel_val = hpx_r;
      IN_PY:   in_sel_val = hpy_r;
      IN_QX:   in_sel_val = hqx_r;
      IN_QY:   in_sel_val = hqy_r;
      IN_CA:   in_sel_val = ca_r;
      default: in_sel_val = '0;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_ADD:  simple_res = add_m(rda_r, rdb_r, mod_r);
      OP_SUB:  simple_res = sub_m(rda_r, rdb_r, mod_r);
      OP_MOV:  simple_res = rda_r;
      OP_ONE:  simple_res = W'(1);
      OP_LDM:  simple_res = mod_r;
      default: simple_res = '0;
    endcase
  end

  assign simple_op = !(op_r inside {OP_MUL, OP_DIV, OP_RED});
  // quotient of p by 1 is p itself, which reduces to 0
  assign qfix = (acc_r == mod_r) ? '0 : acc_r;
  assign trial = {rem_r, u_r[W-1]};
  assign trial_diff = trial - {1'b0, v_r};

  always_comb begin
    we = 1'b0;
    waddr = dst_r;
    wdata = simple_res;
    done = 1'b0;
    state_nxt = state_r;
    case (state_r)
      D_IDLE: if (cmd.start) state_nxt = D_EXEC;
      D_EXEC: begin
        if (simple_op) begin
          we = !(op_r inside {OP_CMP, OP_SHN});
          done = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          state_nxt = D_ITER;
        end
      end
      D_ITER: if (cnt_r == '0) state_nxt = D_FIN;
      D_FIN: begin
        we = 1'b1;
        if (op_r == OP_MUL) wdata = acc_r;
        else if (op_r == OP_DIV) wdata = qfix;
        else wdata = rem_r;
        if (op_r == OP_DIV) begin
          state_nxt = D_WR2;
        end else begin
          done = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      D_WR2: begin
        we = 1'b1;
        waddr = dst2_r;
        wdata = rem_r;
        done = 1'b1;
        state_nxt = D_IDLE;
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      mod_r <= W'(23);
      ca_r <= W'(1);
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == CFG_MODULUS) mod_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_CURVE_A) ca_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hpx_r <= in_px;
      hpy_r <= in_py;
      hqx_r <= in_qx;
      hqy_r <= in_qy;
      n_r <= in_scalar;
      mul_r <= in_req_type;
    end else if (state_r == D_EXEC && op_r == OP_SHN) begin
      n_r <= {n_r[W-2:0], 1'b0};
    end
    if (state_r == D_IDLE && cmd.start) begin
      op_r <= cmd.op;
      dst_r <= cmd.dst;
      dst2_r <= cmd.dst2;
      insel_r <= cmd.insel;
      rda_r <= mem[cmd.srca];
      rdb_r <= mem[cmd.srcb];
    end
    if (we) mem[waddr] <= wdata;
    if (we && waddr == R_RX) rx_r <= wdata;
    if (we && waddr == R_RY) ry_r <= wdata;
    case (state_r)
      D_EXEC: begin
        eq_r <= (rda_r == rdb_r);
        az_r <= (rda_r == '0);
        a1_r <= (rda_r == W'(1));
        acc_r <= '0;
        rem_r <= '0;
        cnt_r <= CW'(W - 1);
        if (op_r == OP_RED) begin
          u_r <= in_sel_val;
          v_r <= mod_r;
        end else begin
          u_r <= rda_r;
          v_r <= rdb_r;
        end
      end
      D_ITER: begin
        cnt_r <= cnt_r - CW'(1);
        if (op_r == OP_MUL) begin
          if (v_r[0]) acc_r <= add_m(acc_r, u_r, mod_r);
          u_r <= add_m(u_r, u_r, mod_r);
          v_r <= {1'b0, v_r[W-1:1]};
        end else begin
          // one restoring division step
          u_r <= {u_r[W-2:0], 1'b0};
          if (!trial_diff[W]) begin
            rem_r <= trial_diff[W-1:0];
            acc_r <= {acc_r[W-2:0], 1'b1};
          end else begin
            rem_r <= trial[W-1:0];
            acc_r <= {acc_r[W-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  assign st.done = done;
  assign st.eq = eq_r;
  assign st.az = az_r;
  assign st.a1 = a1_r;
  assign st.nbit = n_r[W-1];
  assign st.req_mul = mul_r;
  assign st.msmall = (mod_r < W'(2));
  assign rx = rx_r;
  assign ry = ry_r;

  `EC_ASSERT_IMP(a_start_when_idle, cmd.start, state_r == D_IDLE)
  `EC_ASSERT_NXT(a_done_returns_idle, done, state_r == D_IDLE)

endmodule
`default_nettype wire

/* design/ecpa_ctrl.sv */
// Controller: microprogram sequencer driving the datapath.
`default_nettype none
`include "ec_point_add_and_multiply_top_macros.svh"
module ecpa_ctrl import ecpa_pkg::*; #(
  parameter int W = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t st,
  output logic       res_inf
);

  localparam int CNTW = $clog2(W + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  pc_t pc_r, pc_nxt, ret_r, ret_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic s_inf_r, s_inf_nxt, t_inf_r, t_inf_nxt, r_inf_r, r_inf_nxt;
  uop_t u;
  logic cond_ok, in_fire;

  assign u = ucode(pc_r);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_fire = in_valid && in_ready;
  assign res_inf = r_inf_r;

  always_comb begin
    case (u.cond)
      C_MSMALL: cond_ok = st.msmall;
      C_MUL:    cond_ok = st.req_mul;
      C_NBIT0:  cond_ok = !st.nbit;
      C_MORE:   cond_ok = (cnt_r != '0);
      C_SINF:   cond_ok = s_inf_r;
      C_TINF:   cond_ok = t_inf_r;
      C_EQ:     cond_ok = st.eq;
      C_NEQ:    cond_ok = !st.eq;
      C_AZ:     cond_ok = st.az;
      C_NA1:    cond_ok = !st.a1;
      default:  cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    cmd.start = (state_r == S_RUN) && (u.kind == K_DP);
    cmd.capture = in_fire;
    cmd.op = u.op;
    cmd.dst = u.dst;
    cmd.dst2 = u.dst2;
    cmd.srca = u.srca;
    cmd.srcb = u.srcb;
    cmd.insel = u.insel;
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r;
    ret_nxt = ret_r;
    cnt_nxt = cnt_r;
    s_inf_nxt = s_inf_r;
    t_inf_nxt = t_inf_r;
    r_inf_nxt = r_inf_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_RUN;
          pc_nxt = '0;
          cnt_nxt = CNTW'(W);
        end
      end
      S_RUN: begin
        case (u.kind)
          K_DP: begin
            state_nxt = S_WAIT;
            if (u.op == OP_SHN) cnt_nxt = cnt_r - CNTW'(1);
          end
          K_BR:   pc_nxt = cond_ok ? u.target : pc_r + pc_t'(1);
          K_JMP:  pc_nxt = u.target;
          K_CALL: begin
            ret_nxt = pc_r + pc_t'(1);
            pc_nxt = u.target;
          end
          K_RET:  pc_nxt = ret_r;
          K_SET: begin
            pc_nxt = pc_r + pc_t'(1);
            case (u.fset)
              F_ADD_INIT: begin s_inf_nxt = 1'b0; t_inf_nxt = 1'b0; end
              F_DBL:      begin s_inf_nxt = r_inf_r; t_inf_nxt = r_inf_r; end
              F_ADDP:     begin s_inf_nxt = r_inf_r; t_inf_nxt = 1'b0; end
              F_R_T:      r_inf_nxt = t_inf_r;
              F_R_S:      r_inf_nxt = s_inf_r;
              F_R_ZERO:   r_inf_nxt = 1'b0;
              F_R_ONE:    r_inf_nxt = 1'b1;
              default:    r_inf_nxt = r_inf_r;
            endcase
          end
          K_END:   state_nxt = S_OUT;
          default: state_nxt = S_OUT;
        endcase
      end
      S_WAIT: begin
        // advance once the datapath finishes
        if (st.done) begin
          state_nxt = S_RUN;
          pc_nxt = pc_r + pc_t'(1);
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r <= '0;
      ret_r <= '0;
      cnt_r <= '0;
      s_inf_r <= 1'b0;
      t_inf_r <= 1'b0;
      r_inf_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      ret_r <= ret_nxt;
      cnt_r <= cnt_nxt;
      s_inf_r <= s_inf_nxt;
      t_inf_r <= t_inf_nxt;
      r_inf_r <= r_inf_nxt;
    end
  end

  `EC_ASSERT_IMP(a_done_only_waiting, st.done, state_r == S_WAIT)
  `EC_ASSERT_NXT(a_accept_starts_program, in_fire, state_r == S_RUN && pc_r == '0)

endmodule
`default_nettype wire

/* design/ec_point_add_and_multiply_top.sv */
// Datapath ops: add, sub and move complete in the execute state; multiply, reduce and divide
// iterate serially, and divide also writes its remainder. A point add takes the chord or the
// tangent path, plus Euclid steps for the inverse. A request takes one point add; a scalar
// multiply up to 2W point adds, so run time is set by the serial multiply and divide.
// Throughput: one request in flight; the next word is taken after the result is taken.
// Reset: modulus 23, curve_a 1, controller idle; register file entries are written before use.
`default_nettype none
module ec_point_add_and_multiply_top import ecpa_pkg::*; #(
  parameter int FIELD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ecpa_in_if.sink               in_ch,
  ecpa_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [FIELD_BITS-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       res_inf;
  logic [FIELD_BITS-1:0] rx, ry;

  ecpa_ctrl #(.W(FIELD_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .st        (st),
    .res_inf   (res_inf)
  );

  ecpa_dp #(.W(FIELD_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_req_type (in_ch.req_type),
    .in_px       (in_ch.px),
    .in_py       (in_ch.py),
    .in_qx       (in_ch.qx),
    .in_qy       (in_ch.qy),
    .in_scalar   (in_ch.scalar),
    .cmd         (cmd),
    .st          (st),
    .rx          (rx),
    .ry          (ry)
  );

  // infinity reads out as zero coordinates
  assign out_ch.rx = res_inf ? '0 : rx;
  assign out_ch.ry = res_inf ? '0 : ry;
  assign out_ch.at_infinity = res_inf;

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the elliptic curve point add and multiply unit.
module tb_top import ecpa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 16;
  localparam longint CYCLE_LIMIT = 64'd60000000;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    logic  rt;
    bit [W-1:0] px, py, qx, qy, n;
  } ec_req_t;

  typedef struct {
    bit [W-1:0] x, y;
    bit inf;
  } ec_res_t;

  typedef struct {
    ec_req_t req;
    bit      fixed;
    ec_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;

  ecpa_in_if #(.W(W)) in_ch ();
  ecpa_out_if #(.W(W)) out_ch ();

  ec_point_add_and_multiply_top #(.FIELD_BITS(W)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the two registers
  bit [W-1:0] fld_p = 16'd23;
  bit [W-1:0] fld_a = 16'd1;

  ec_res_t expected_pts[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.px = '0;
    in_ch.py = '0;
    in_ch.qx = '0;
    in_ch.qy = '0;
    in_ch.scalar = '0;
    out_ch.ready = 1'b0;
  end

  function automatic bit [W-1:0] fadd(bit [W-1:0] u, bit [W-1:0] v, bit [W-1:0] m);
    bit [W:0] s;
    s = u + v;
    return (s >= m) ? W'(s - m) : W'(s);
  endfunction

  function automatic bit [W-1:0] fsub(bit [W-1:0] u, bit [W-1:0] v, bit [W-1:0] m);
    return (u >= v) ? u - v : W'({1'b0, u} + m - v);
  endfunction

  function automatic bit [W-1:0] fmul(bit [W-1:0] u, bit [W-1:0] v, bit [W-1:0] m);
    bit [2*W-1:0] pr;
    pr = u * v;
    return W'(pr % m);
  endfunction

  function automatic bit finv(bit [W-1:0] v, bit [W-1:0] m, output bit [W-1:0] res);
    bit [W-1:0] r0, r1, r2, t0, t1, t2, q;
    r0 = m; r1 = v; t0 = 0; t1 = 1;
    res = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      t2 = fsub(t0, fmul(q % m, t1, m), m);
      r0 = r1; r1 = r2;
      t0 = t1; t1 = t2;
    end
    if (r0 != 1) return 1'b0;
    res = t0;
    return 1'b1;
  endfunction

  function automatic ec_res_t point_sum(ec_res_t s, ec_res_t t, bit [W-1:0] m, bit [W-1:0] ca);
    ec_res_t r;
    bit [W-1:0] num, den, iv, lam, x3;
    r = '{0, 0, 1'b1};
    if (s.inf) return t;
    if (t.inf) return s;
    if (s.x != t.x) begin
      num = fsub(t.y, s.y, m);
      den = fsub(t.x, s.x, m);
    end else begin
      if (s.y != t.y || s.y == 0) return r;
      num = fadd(fmul(3 % m, fmul(s.x, s.x, m), m), ca, m);
      den = fmul(2 % m, s.y, m);
    end
    if (den == 0 || !finv(den, m, iv)) return r;
    lam = fmul(num, iv, m);
    x3 = fsub(fsub(fmul(lam, lam, m), s.x, m), t.x, m);
    r.x = x3;
    r.y = fsub(fmul(lam, fsub(s.x, x3, m), m), s.y, m);
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic ec_res_t predict_point(ec_req_t rq);
    ec_res_t res, p, q;
    bit [W-1:0] ca;
    res = '{0, 0, 1'b1};
    if (fld_p >= 2) begin
      ca = fld_a % fld_p;
      p = '{rq.px % fld_p, rq.py % fld_p, 1'b0};
      if (rq.rt == 1'b0) begin
        q = '{rq.qx % fld_p, rq.qy % fld_p, 1'b0};
        res = point_sum(p, q, fld_p, ca);
      end else begin
        for (int i = W - 1; i >= 0; i--) begin
          res = point_sum(res, res, fld_p, ca);
          if (rq.n[i]) res = point_sum(res, p, fld_p, ca);
        end
      end
    end
    if (res.inf) begin
      res.x = 0;
      res.y = 0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("tb_top: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver: random stall, check each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pts.size() == 0) begin
          report_mismatch("unexpected word rx", out_ch.rx, -1);
        end else begin
          ec_res_t e;
          e = expected_pts.pop_front();
          if (out_ch.rx !== e.x) report_mismatch("rx", out_ch.rx, e.x);
          if (out_ch.ry !== e.y) report_mismatch("ry", out_ch.ry, e.y);
          if (out_ch.at_infinity !== e.inf)
            report_mismatch("at_infinity", out_ch.at_infinity, e.inf);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(cfg_idx_t idx, bit [W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MODULUS) fld_p = val;
    else fld_a = val;
  endtask

  task automatic wait_drained();
    while (expected_pts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // offer one word; valid stays high while the next word follows at once
  task automatic send_point_req(ec_req_t rq, bit fixed, ec_res_t want);
    ec_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= rq.rt;
    in_ch.px <= rq.px;
    in_ch.py <= rq.py;
    in_ch.qx <= rq.qx;
    in_ch.qy <= rq.qy;
    in_ch.scalar <= rq.n;
    pred = predict_point(rq);
    if (fixed && (pred.x != want.x || pred.y != want.y || pred.inf != want.inf))
      $display("tb_top: note, table row disagrees with predictor");
    do @(posedge clk); while (!in_ch.ready);
    expected_pts.push_back(fixed ? want : pred);
  endtask

  function automatic ec_req_t rand_req(bit [W-1:0] m);
    ec_req_t r;
    r.rt = $urandom_range(3) == 0;
    r.px = ($urandom_range(9) == 0) ? W'($urandom) : W'($urandom_range(m - 1));
    r.py = ($urandom_range(9) == 0) ? W'($urandom) : W'($urandom_range(m - 1));
    case ($urandom_range(3))
      0: begin r.qx = r.px; r.qy = r.py; end
      1: begin r.qx = r.px; r.qy = W'($urandom_range(m - 1)); end
      default: begin r.qx = W'($urandom); r.qy = W'($urandom); end
    endcase
    // mostly short scalars keep the run short; a few use every bit
    r.n = ($urandom_range(7) == 0) ? W'($urandom) : W'($urandom_range(40));
    return r;
  endfunction

  stim_row_t directed[$];
  ec_res_t inf_pt = '{0, 0, 1'b1};

  task automatic add_row(logic rt, int px, int py, int qx, int qy, int n,
                         bit fixed, ec_res_t want);
    stim_row_t s;
    s.req = '{rt, W'(px), W'(py), W'(qx), W'(qy), W'(n)};
    s.fixed = fixed;
    s.res = want;
    directed.push_back(s);
  endtask

  initial begin
    ec_res_t none;
    ec_req_t rq;
    bit [W-1:0] mods[6];
    none = '{0, 0, 1'b0};
    mods = '{16'd23, 16'd3, 16'd65521, 16'd97, 16'd15, 16'd65535};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset settings (p=23, a=1)
    add_row(1'b0, 3, 10, 9, 7, 0, 1'b0, none);          // chord
    add_row(1'b0, 3, 10, 3, 10, 0, 1'b0, none);         // tangent
    add_row(1'b0, 3, 10, 3, 13, 0, 1'b1, inf_pt);       // P + (-P)
    add_row(1'b0, 5, 0, 5, 0, 0, 1'b1, inf_pt);         // doubling with y zero
    add_row(1'b1, 3, 10, 0, 0, 0, 1'b1, inf_pt);        // zero scalar
    add_row(1'b1, 3, 10, 0, 0, 1, 1'b1, '{3, 10, 1'b0}); // scalar one
    add_row(1'b1, 3, 10, 0, 0, 2, 1'b0, none);
    add_row(1'b1, 3, 10, 0, 0, 16'hffff, 1'b0, none);
    add_row(1'b0, 16'hffff, 16'hffff, 0, 0, 0, 1'b0, none);
    add_row(1'b0, 0, 0, 16'hffff, 16'hffff, 0, 1'b0, none);
    add_row(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 1'b0, none);
    add_row(1'b0, 1, 2, 2, 1, 16'hffff, 1'b0, none);
    foreach (directed[i]) send_point_req(directed[i].req, directed[i].fixed, directed[i].res);
    in_ch.valid <= 1'b0;
    wait_drained();

    // degenerate modulus: everything is infinity
    write_reg(CFG_MODULUS, 16'd1);
    send_point_req('{1'b0, 16'd3, 16'd4, 16'd5, 16'd6, 16'd0}, 1'b1, inf_pt);
    send_point_req('{1'b1, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7}, 1'b1, inf_pt);
    in_ch.valid <= 1'b0;
    wait_drained();
    write_reg(CFG_MODULUS, 16'd0);
    send_point_req('{1'b0, 16'd3, 16'd4, 16'd9, 16'd6, 16'd0}, 1'b1, inf_pt);
    in_ch.valid <= 1'b0;
    wait_drained();

    // random phases across settings and idling profiles
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MODULUS, mods[ph]);
      write_reg(CFG_CURVE_A, (ph == 1) ? 16'hffff : (ph == 2) ? 16'd0 : W'($urandom));
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 60; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 60; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int k = 0; k < 20; k++) begin
        rq = rand_req(mods[ph]);
        send_point_req(rq, 1'b0, none);
        // hold off until all results are in
        if (k == 10) begin
          in_ch.valid <= 1'b0;
          while (expected_pts.size() != 0) @(posedge clk);
        end
      end
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
